// ===== rtl/core/ifct_pkg.sv =====
// Shared types, character constants and helper functions of the format code translator.
package ifct_pkg;

    // Character codes
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_PCT   = 16'h0025;
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_MINUS = 16'h002D;
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [15:0] CH_NINE  = 16'h0039;
    localparam logic [15:0] CH_UP_B  = 16'h0042;
    localparam logic [15:0] CH_UP_D  = 16'h0044;
    localparam logic [15:0] CH_UP_O  = 16'h004F;
    localparam logic [15:0] CH_UP_R  = 16'h0052;
    localparam logic [15:0] CH_UP_S  = 16'h0053;
    localparam logic [15:0] CH_UP_U  = 16'h0055;
    localparam logic [15:0] CH_LO_B  = 16'h0062;
    localparam logic [15:0] CH_LO_C  = 16'h0063;
    localparam logic [15:0] CH_LO_F  = 16'h0066;
    localparam logic [15:0] CH_DEL   = 16'h007F;
    localparam logic [15:0] CH_PIC   = 16'h2400;  // control picture base
    localparam logic [15:0] CH_PIC_DEL = 16'h2421;

    // Input control codes
    localparam logic [15:0] CC_BOLD    = 16'h0002;
    localparam logic [15:0] CC_COLOR   = 16'h0003;
    localparam logic [15:0] CC_TAB     = 16'h0009;
    localparam logic [15:0] CC_RESET   = 16'h000F;
    localparam logic [15:0] CC_REV_A   = 16'h0012;
    localparam logic [15:0] CC_REV_B   = 16'h0016;
    localparam logic [15:0] CC_ITALIC  = 16'h001D;
    localparam logic [15:0] CC_ULINE   = 16'h001F;
    localparam logic [15:0] CC_FIRST_PRINT = 16'h0020;

    // Queue depth
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Colour sequence parser state
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_START = 3'd1,
        MODE_FG1   = 3'd2,
        MODE_FG2   = 3'd3,
        MODE_COMMA = 3'd4,
        MODE_BG1   = 3'd5
    } t_mode_e;

    // Pending colour sequence output
    typedef enum logic [2:0] {
        FL_NONE   = 3'd0,
        FL_DASH   = 3'd1,   // %Dc-
        FL_FG     = 3'd2,   // %Dcf nn
        FL_FG_CMA = 3'd3,   // %Dcf nn ,
        FL_FG_BG  = 3'd4    // %Dcf nn %Dcb nn
    } t_flush_e;

    // Output of the character itself
    typedef enum logic [1:0] {
        PL_NONE   = 2'd0,
        PL_PAIR   = 2'd1,   // '%' then letter
        PL_SPACES = 2'd2,   // eight spaces
        PL_SINGLE = 2'd3
    } t_plain_e;

    // One command: everything an input item expands into
    typedef struct packed {
        t_flush_e    flush;
        logic [3:0]  fg_hi;
        logic [3:0]  fg_lo;
        logic [3:0]  bg_hi;
        logic [3:0]  bg_lo;
        t_plain_e    plain;
        logic        twice;   // single character emitted twice
        logic [15:0] ch;
        logic        fin;     // end result follows
    } t_cmd;

    function automatic logic [15:0] digit_char(input logic [3:0] d);
        digit_char = CH_ZERO | {12'h000, d};
    endfunction

    function automatic logic [4:0] flush_len(input t_flush_e f);
        case (f)
            FL_DASH:   flush_len = 5'd4;
            FL_FG:     flush_len = 5'd6;
            FL_FG_CMA: flush_len = 5'd7;
            FL_FG_BG:  flush_len = 5'd12;
            default:   flush_len = 5'd0;
        endcase
    endfunction

    function automatic logic [4:0] plain_len(input t_plain_e p, input logic twice);
        case (p)
            PL_PAIR:   plain_len = 5'd2;
            PL_SPACES: plain_len = 5'd8;
            PL_SINGLE: plain_len = twice ? 5'd2 : 5'd1;
            default:   plain_len = 5'd0;
        endcase
    endfunction

    // Character at a position of the colour sequence text
    function automatic logic [15:0] flush_char(input t_cmd c, input logic [3:0] idx);
        case (idx)
            4'd0:    flush_char = CH_PCT;
            4'd1:    flush_char = CH_UP_D;
            4'd2:    flush_char = CH_LO_C;
            4'd3:    flush_char = (c.flush == FL_DASH) ? CH_MINUS : CH_LO_F;
            4'd4:    flush_char = digit_char(c.fg_hi);
            4'd5:    flush_char = digit_char(c.fg_lo);
            4'd6:    flush_char = (c.flush == FL_FG_CMA) ? CH_COMMA : CH_PCT;
            4'd7:    flush_char = CH_UP_D;
            4'd8:    flush_char = CH_LO_C;
            4'd9:    flush_char = CH_LO_B;
            4'd10:   flush_char = digit_char(c.bg_hi);
            4'd11:   flush_char = digit_char(c.bg_lo);
            default: flush_char = CH_PCT;
        endcase
    endfunction

endpackage

// ===== rtl/core/irc_char_if.sv =====
// Stream interfaces for input characters and translated output characters.
interface irc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

interface irc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_char;
    logic        char_valid;
    logic        string_end;
    logic        last_of_run;

    modport source (output valid, output out_char, output char_valid, output string_end,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_char, input char_valid, input string_end,
                    input last_of_run, output ready);
endinterface

// ===== rtl/core/irc_format_code_translator_core.sv =====
// Top level of the IRC format code translator.
//
// Input channel i_in carries one UTF-16 code unit per item, or an end marker
// that closes the string. Output channel o_out carries one translated code
// unit per item; the item after the flushed text of an end marker has
// char_valid low and string_end high, and last_of_run marks the final output
// item caused by each input item.
// The front end parses colour sequences and pushes one command per input item
// that produces output into a four-entry queue; items absorbed into a colour
// sequence produce none. The back end expands the head command, one output
// item per cycle while the receiver does not stall, into a registered output stage.
// An accepted input item's command is written into the queue; the back end
// then loads its output items from the queue head into the output stage.
// Throughput: while the receiver does not stall, one input item per cycle while
// each gives at most one output; otherwise one output item per cycle, up to twenty for a single input item.
// Reset (synchronous, active low) empties the queue and output stage and
// returns the parser to idle. When the receiver stalls, the output item holds
// and the queue fills; the input is held off only once the queue is full.
module irc_format_code_translator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    irc_in_if.sink    i_in,
    irc_out_if.source o_out
);

    ifct_pkg::t_cmd push_cmd, head_cmd;
    logic push, pop, q_full, q_empty;
    logic in_ready;

    ifct_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (in_ready),
        .i_char_code  (i_in.char_code),
        .i_end_marker (i_in.end_marker),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    assign i_in.ready = in_ready;

    ifct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    ifct_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_out_char    (o_out.out_char),
        .o_char_valid  (o_out.char_valid),
        .o_string_end  (o_out.string_end),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule

// ===== rtl/core/ifct_front.sv =====
// Front end: accepts items, tracks the colour sequence and builds one command per item that produces output.
module ifct_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_char_code,
    input  logic          i_end_marker,
    input  logic          i_q_full,
    output logic          o_push,
    output ifct_pkg::t_cmd o_cmd
);

    ifct_pkg::t_mode_e r_mode, n_mode;
    logic [3:0] r_fg1, n_fg1;
    logic [3:0] r_fg2, n_fg2;
    logic [3:0] r_bg1, n_bg1;

    logic       accept;
    logic       is_dig;
    logic [3:0] dval;
    logic       held;     // item absorbed into the sequence
    ifct_pkg::t_cmd cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_dig  = (i_char_code >= ifct_pkg::CH_ZERO) && (i_char_code <= ifct_pkg::CH_NINE);
    assign dval    = i_char_code[3:0];

    // Sequence parser and command build
    always_comb begin
        n_mode = r_mode;
        n_fg1  = r_fg1;
        n_fg2  = r_fg2;
        n_bg1  = r_bg1;
        held   = 1'b0;
        cmd        = '0;
        cmd.flush  = ifct_pkg::FL_NONE;
        cmd.plain  = ifct_pkg::PL_NONE;
        cmd.ch     = i_char_code;

        // digits and commas taken into the sequence
        if (!i_end_marker) begin
            case (r_mode)
                ifct_pkg::MODE_START: begin
                    if (is_dig) begin
                        n_fg1 = dval; n_mode = ifct_pkg::MODE_FG1; held = 1'b1;
                    end
                end
                ifct_pkg::MODE_FG1: begin
                    if (is_dig) begin
                        n_fg2 = dval; n_mode = ifct_pkg::MODE_FG2; held = 1'b1;
                    end else if (i_char_code == ifct_pkg::CH_COMMA) begin
                        n_fg2 = r_fg1; n_fg1 = 4'd0;
                        n_mode = ifct_pkg::MODE_COMMA; held = 1'b1;
                    end
                end
                ifct_pkg::MODE_FG2: begin
                    if (i_char_code == ifct_pkg::CH_COMMA) begin
                        n_mode = ifct_pkg::MODE_COMMA; held = 1'b1;
                    end
                end
                ifct_pkg::MODE_COMMA: begin
                    if (is_dig) begin
                        n_bg1 = dval; n_mode = ifct_pkg::MODE_BG1; held = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (!i_end_marker && r_mode == ifct_pkg::MODE_BG1 && is_dig) begin
            // second background digit completes the sequence
            cmd.flush = ifct_pkg::FL_FG_BG;
            cmd.fg_hi = r_fg1; cmd.fg_lo = r_fg2;
            cmd.bg_hi = r_bg1; cmd.bg_lo = dval;
            n_mode = ifct_pkg::MODE_IDLE;
        end else if (!held) begin
            // flush whatever is pending
            cmd.fg_hi = r_fg1; cmd.fg_lo = r_fg2;
            case (r_mode)
                ifct_pkg::MODE_START: cmd.flush = ifct_pkg::FL_DASH;
                ifct_pkg::MODE_FG1: begin
                    cmd.flush = ifct_pkg::FL_FG;
                    cmd.fg_hi = 4'd0; cmd.fg_lo = r_fg1;
                    n_fg2 = r_fg1; n_fg1 = 4'd0;
                end
                ifct_pkg::MODE_FG2:   cmd.flush = ifct_pkg::FL_FG;
                ifct_pkg::MODE_COMMA: cmd.flush = ifct_pkg::FL_FG_CMA;
                ifct_pkg::MODE_BG1: begin
                    cmd.flush = ifct_pkg::FL_FG_BG;
                    cmd.bg_hi = 4'd0; cmd.bg_lo = r_bg1;
                end
                default: cmd.flush = ifct_pkg::FL_NONE;
            endcase
            n_mode = ifct_pkg::MODE_IDLE;

            // translate the character itself
            if (i_end_marker) begin
                cmd.fin = 1'b1;
            end else if (i_char_code == ifct_pkg::CC_COLOR) begin
                n_mode = ifct_pkg::MODE_START;
            end else if (i_char_code < ifct_pkg::CC_FIRST_PRINT) begin
                cmd.plain = ifct_pkg::PL_PAIR;
                case (i_char_code)
                    ifct_pkg::CC_BOLD:   cmd.ch = ifct_pkg::CH_UP_B;
                    ifct_pkg::CC_RESET:  cmd.ch = ifct_pkg::CH_UP_O;
                    ifct_pkg::CC_REV_A:  cmd.ch = ifct_pkg::CH_UP_R;
                    ifct_pkg::CC_REV_B:  cmd.ch = ifct_pkg::CH_UP_R;
                    ifct_pkg::CC_ITALIC: cmd.ch = ifct_pkg::CH_UP_S;
                    ifct_pkg::CC_ULINE:  cmd.ch = ifct_pkg::CH_UP_U;
                    ifct_pkg::CC_TAB: begin
                        cmd.plain = ifct_pkg::PL_SPACES;
                        cmd.ch    = ifct_pkg::CH_SPACE;
                    end
                    default: begin
                        cmd.plain = ifct_pkg::PL_SINGLE;
                        cmd.ch    = ifct_pkg::CH_PIC + i_char_code;
                    end
                endcase
            end else if (i_char_code == ifct_pkg::CH_DEL) begin
                cmd.plain = ifct_pkg::PL_SINGLE;
                cmd.ch    = ifct_pkg::CH_PIC_DEL;
            end else begin
                cmd.plain = ifct_pkg::PL_SINGLE;
                cmd.twice = (i_char_code == ifct_pkg::CH_PCT);
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && !held &&
                    ((cmd.flush != ifct_pkg::FL_NONE) || (cmd.plain != ifct_pkg::PL_NONE)
                     || cmd.fin);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ifct_pkg::MODE_IDLE;
            r_fg1  <= 4'd0;
            r_fg2  <= 4'd0;
            r_bg1  <= 4'd0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_fg1  <= n_fg1;
            r_fg2  <= n_fg2;
            r_bg1  <= n_bg1;
        end
    end

endmodule

// ===== rtl/core/ifct_queue.sv =====
// Short command queue between front and back end.
module ifct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ifct_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ifct_pkg::t_cmd o_head
);

    ifct_pkg::t_cmd r_mem [ifct_pkg::QDEPTH];
    logic [ifct_pkg::QAW-1:0] r_wp, r_rp;
    logic [ifct_pkg::QAW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (ifct_pkg::QAW+1)'(ifct_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/ifct_back.sv =====
// Back end: expands the head command into output characters, one a cycle while the receiver does not stall.
module ifct_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ifct_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [15:0]    o_out_char,
    output logic           o_char_valid,
    output logic           o_string_end,
    output logic           o_last_of_run
);

    logic [4:0]  r_idx, n_idx;
    logic        r_valid;
    logic [15:0] r_char;
    logic        r_cval, r_send, r_last;

    logic [4:0]  flen, plen, total, pidx;
    logic        load, last;
    logic [15:0] ch;
    logic        is_end;

    assign flen  = ifct_pkg::flush_len(i_head.flush);
    assign plen  = ifct_pkg::plain_len(i_head.plain, i_head.twice);
    assign total = flen + plen + {4'd0, i_head.fin};
    assign last  = (r_idx == total - 5'd1);
    assign pidx  = r_idx - flen;
    assign load  = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && last;

    // Character at the current position
    always_comb begin
        is_end = 1'b0;
        if (r_idx < flen) begin
            ch = ifct_pkg::flush_char(i_head, r_idx[3:0]);
        end else if (pidx < plen) begin
            if (i_head.plain == ifct_pkg::PL_PAIR && pidx == 5'd0) ch = ifct_pkg::CH_PCT;
            else ch = i_head.ch;
        end else begin
            ch     = 16'h0000;
            is_end = 1'b1;
        end
    end

    assign n_idx = last ? 5'd0 : r_idx + 5'd1;

    // Position counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 5'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_idx   <= n_idx;
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= ch;
            r_cval <= !is_end;
            r_send <= is_end;
            r_last <= last;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_char_valid  = r_cval;
    assign o_string_end  = r_send;
    assign o_last_of_run = r_last;

endmodule
